FILE: hw/rtl/slls_pkg.sv
// ----------------------------------------------------------------------------
// slls_pkg
// Shared constants, codes and controller/datapath interface types for the
// stereo loop layer store.
// ----------------------------------------------------------------------------
package slls_pkg;

   localparam int LOOP_DEPTH  = 65536;
   localparam int SAMPLE_BITS = 24;

   localparam int KIND_W     = 3;
   localparam int POS_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int GAIN_W     = 16;
   localparam int COUNT_W    = 17;
   localparam int PEAK_IDX_W = 16;

   localparam logic [KIND_W-1:0] KIND_APPEND  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_OVERDUB = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PLAY    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RESTART = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLES_PER_PEAK = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAIN_GAIN        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER_GAIN       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_PAN_GAIN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_PAN_GAIN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIX_ENABLE       = 3'd5;

   localparam logic [GAIN_W-1:0] SPP_RESET  = 16'd0;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;
   localparam logic [GAIN_W-1:0] PAN_RESET  = 16'd23170;

   typedef struct packed {
      logic load;
      logic exec;
      logic scale;
      logic emit_play;
      logic emit_write;
      logic emit_misc;
      logic sweep;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_write;
      logic is_play;
      logic is_clear;
      logic sweep_last;
   } dp_status_type;

endpackage

FILE: hw/rtl/slls_ram.sv
// ----------------------------------------------------------------------------
// slls_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module slls_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/slls_ctrl.sv
// ----------------------------------------------------------------------------
// slls_ctrl
// Sequencer: accepts a command, steps the datapath through read, execute,
// scale and emit as the command kind requires, and runs the memory clearing sweep.
// ----------------------------------------------------------------------------
module slls_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_strobe,
   output slls_pkg::ctrl_cmd_type  cmd,
   input  slls_pkg::dp_status_type status
);

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_SCALE,
      ST_MIX,
      ST_PEAK
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      case (state_ff)
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.load = start;
            if (start) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (status.is_write || status.is_play) begin
               state_in = ST_EXEC;
            end else begin
               cmd.emit_misc = 1'b1;
               state_in = status.is_clear ? ST_SWEEP : ST_IDLE;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.is_play ? ST_SCALE : ST_PEAK;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            cmd.emit_play = 1'b1;
            state_in = ST_IDLE;
         end
         ST_PEAK: begin
            cmd.emit_write = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      strobe_in = cmd.emit_play | cmd.emit_write | cmd.emit_misc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_SWEEP;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_READ || $past(state_ff) == ST_MIX ||
                      $past(state_ff) == ST_PEAK))
      else $error("result strobe without an emit step");

   a_sweep_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && $past(state_ff) != ST_SWEEP) |-> $past(status.is_clear))
      else $error("clearing sweep started without a clear command");

endmodule

FILE: hw/rtl/slls_datapath.sv
// ----------------------------------------------------------------------------
// slls_datapath
// Loop memory, configuration registers, overdub saturation, play gain chain
// and windowed peak meter.
// ----------------------------------------------------------------------------
module slls_datapath #(
   parameter int LOOP_DEPTH  = slls_pkg::LOOP_DEPTH,
   parameter int SAMPLE_BITS = slls_pkg::SAMPLE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [slls_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [slls_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic [slls_pkg::KIND_W-1:0]          req_kind,
   input  logic [slls_pkg::POS_W-1:0]           req_position,
   input  logic signed [SAMPLE_BITS-1:0]        req_in_left,
   input  logic signed [SAMPLE_BITS-1:0]        req_in_right,
   input  logic signed [SAMPLE_BITS-1:0]        req_bus_left,
   input  logic signed [SAMPLE_BITS-1:0]        req_bus_right,
   input  slls_pkg::ctrl_cmd_type               cmd,
   output slls_pkg::dp_status_type              status,
   output logic signed [SAMPLE_BITS-1:0]        rsp_out_left,
   output logic signed [SAMPLE_BITS-1:0]        rsp_out_right,
   output logic                                 rsp_peak_valid,
   output logic [SAMPLE_BITS-1:0]               rsp_peak_value,
   output logic [slls_pkg::PEAK_IDX_W-1:0]      rsp_peak_index,
   output logic [slls_pkg::COUNT_W-1:0]         rsp_stored_count
);

   localparam int SB    = SAMPLE_BITS;
   localparam int AW    = $clog2(LOOP_DEPTH);
   localparam int CW    = $clog2(LOOP_DEPTH + 1);
   localparam int VW    = (CW > slls_pkg::COUNT_W) ? CW : slls_pkg::COUNT_W;
   localparam int PW    = (AW > slls_pkg::POS_W) ? AW : slls_pkg::POS_W;
   localparam int WS_W  = slls_pkg::POS_W + 1;
   localparam int WSUM_W = WS_W + 1;
   localparam int GW    = 20;
   localparam int GCW   = 21;
   localparam int PRODW = SB + GCW + 1;
   localparam int SHW   = PRODW - 12;
   localparam int MIXW  = SB + 11;
   localparam int PIW   = slls_pkg::PEAK_IDX_W;

   localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

   function automatic logic signed [SB-1:0] sat_narrow(input logic signed [SB:0] v);
      logic signed [SB-1:0] r;
      if (v[SB] != v[SB-1]) begin
         r = v[SB] ? SMIN : SMAX;
      end else begin
         r = v[SB-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [SB-1:0] sat_wide(input logic signed [MIXW-1:0] v);
      logic signed [SB-1:0] r;
      if (v > MIXW'(SMAX)) begin
         r = SMAX;
      end else if (v < MIXW'(SMIN)) begin
         r = SMIN;
      end else begin
         r = v[SB-1:0];
      end
      return r;
   endfunction

   function automatic logic [SB-1:0] magnitude(input logic signed [SB-1:0] s);
      logic [SB:0] neg;
      neg = -{s[SB-1], s};
      return s[SB-1] ? neg[SB-1:0] : s;
   endfunction

   // configuration
   logic [slls_pkg::GAIN_W-1:0] spp_ff, main_ff, layer_ff, panl_ff, panr_ff;
   logic                        mix_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spp_ff    <= slls_pkg::SPP_RESET;
         main_ff   <= slls_pkg::GAIN_RESET;
         layer_ff  <= slls_pkg::GAIN_RESET;
         panl_ff   <= slls_pkg::PAN_RESET;
         panr_ff   <= slls_pkg::PAN_RESET;
         mix_en_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            slls_pkg::CSR_SAMPLES_PER_PEAK: spp_ff    <= csr_data;
            slls_pkg::CSR_MAIN_GAIN:        main_ff   <= csr_data;
            slls_pkg::CSR_LAYER_GAIN:       layer_ff  <= csr_data;
            slls_pkg::CSR_LEFT_PAN_GAIN:    panl_ff   <= csr_data;
            slls_pkg::CSR_RIGHT_PAN_GAIN:   panr_ff   <= csr_data;
            slls_pkg::CSR_MIX_ENABLE:       mix_en_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // request capture
   logic [slls_pkg::KIND_W-1:0] kind_ff;
   logic [slls_pkg::POS_W-1:0]  pos_ff;
   logic signed [SB-1:0]        inl_ff, inr_ff, busl_ff, busr_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         pos_ff  <= req_position;
         inl_ff  <= req_in_left;
         inr_ff  <= req_in_right;
         busl_ff <= req_bus_left;
         busr_ff <= req_bus_right;
      end
   end

   logic in_range;
   logic is_wr_kind;
   assign in_range   = VW'(pos_ff) < VW'(LOOP_DEPTH);
   assign is_wr_kind = (kind_ff == slls_pkg::KIND_APPEND) ||
                       (kind_ff == slls_pkg::KIND_OVERDUB);

   // sweep counter and memory
   logic [AW-1:0] sweep_ff;
   logic          sweep_last;
   assign sweep_last = (sweep_ff == AW'(LOOP_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.sweep) begin
         sweep_ff <= sweep_last ? '0 : sweep_ff + AW'(1);
      end
   end

   assign status.is_write   = is_wr_kind && in_range;
   assign status.is_play    = (kind_ff == slls_pkg::KIND_PLAY);
   assign status.is_clear   = (kind_ff == slls_pkg::KIND_CLEAR);
   assign status.sweep_last = sweep_last;

   logic [PW-1:0]     pos_ext;
   logic [AW-1:0]     ram_addr;
   logic              ram_we;
   logic [2*SB-1:0]   ram_wdata, ram_rdata;
   logic signed [SB-1:0] st_l, st_r, new_l, new_r;

   assign pos_ext = PW'(pos_ff);
   assign st_l = ram_rdata[2*SB-1:SB];
   assign st_r = ram_rdata[SB-1:0];

   always_comb begin
      if (kind_ff == slls_pkg::KIND_APPEND) begin
         new_l = inl_ff;
         new_r = inr_ff;
      end else begin
         new_l = sat_narrow({st_l[SB-1], st_l} + {inl_ff[SB-1], inl_ff});
         new_r = sat_narrow({st_r[SB-1], st_r} + {inr_ff[SB-1], inr_ff});
      end
   end

   always_comb begin
      if (cmd.sweep) begin
         ram_addr  = sweep_ff;
         ram_we    = 1'b1;
         ram_wdata = '0;
      end else begin
         ram_addr  = pos_ext[AW-1:0];
         ram_we    = cmd.exec && is_wr_kind && in_range;
         ram_wdata = {new_l, new_r};
      end
   end

   slls_ram #(
      .WIDTH (2 * SB),
      .DEPTH (LOOP_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // play gain chain
   logic [31:0]       gmul;
   logic [GW-1:0]     g_ff;
   logic [35:0]       gcl_sum, gcr_sum;
   logic [GCW-1:0]    gcl_ff, gcr_ff;
   logic signed [SB-1:0] stl_ff, str_ff;
   logic signed [PRODW-1:0] prodl_ff, prodr_ff;

   assign gmul    = 32'(main_ff) * 32'(layer_ff) + 32'd2048;
   assign gcl_sum = 36'(g_ff) * 36'(panl_ff) + 36'd16384;
   assign gcr_sum = 36'(g_ff) * 36'(panr_ff) + 36'd16384;

   always_ff @(posedge clock) begin
      g_ff <= gmul[31:12];
      if (cmd.exec) begin
         gcl_ff  <= gcl_sum[35:15];
         gcr_ff  <= gcr_sum[35:15];
         stl_ff  <= in_range ? st_l : '0;
         str_ff  <= in_range ? st_r : '0;
      end
      if (cmd.scale) begin
         prodl_ff <= stl_ff * $signed({1'b0, gcl_ff});
         prodr_ff <= str_ff * $signed({1'b0, gcr_ff});
      end
   end

   logic signed [PRODW-1:0] rndl, rndr;
   logic signed [SHW-1:0]   shl, shr;
   logic signed [SB-1:0]    mixl, mixr;

   assign rndl = prodl_ff + PRODW'(2048);
   assign rndr = prodr_ff + PRODW'(2048);
   assign shl  = rndl[PRODW-1:12];
   assign shr  = rndr[PRODW-1:12];
   assign mixl = mix_en_ff ? sat_wide(MIXW'(busl_ff) + MIXW'(shl)) : busl_ff;
   assign mixr = mix_en_ff ? sat_wide(MIXW'(busr_ff) + MIXW'(shr)) : busr_ff;

   // peak meter, precomputed window bounds
   logic [WS_W-1:0]   ws_ff, ws_in;
   logic [WSUM_W-1:0] wsum, psum, wnext_ff;
   logic              past_ff;
   logic [SB-1:0]     new_l_mag_src, new_r_mag_src;
   logic signed [SB-1:0] newl_ff, newr_ff;

   assign wsum = WSUM_W'(ws_ff) + WSUM_W'(spp_ff);
   assign psum = WSUM_W'(pos_ff) + WSUM_W'(spp_ff);

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         past_ff  <= WSUM_W'(pos_ff) >= wsum;
         wnext_ff <= (WSUM_W'(pos_ff) >= wsum) ? psum : wsum;
         newl_ff  <= new_l;
         newr_ff  <= new_r;
      end
   end

   assign new_l_mag_src = magnitude(newl_ff);
   assign new_r_mag_src = magnitude(newr_ff);

   logic [CW-1:0]  vc_ff, vc_in;
   logic [SB-1:0]  rp_ff, rp_in;
   logic [PIW-1:0] pc_ff, pc_in;
   logic           pv;
   logic [SB-1:0]  pval;
   logic [PIW-1:0] pidx;
   logic [SB-1:0]  m, rp1, rp2;
   logic [WS_W-1:0] ws1;
   logic [VW-1:0]  pos1;
   logic           done;

   always_comb begin
      vc_in = vc_ff;
      ws_in = ws_ff;
      rp_in = rp_ff;
      pc_in = pc_ff;
      pv    = 1'b0;
      pval  = '0;
      pidx  = '0;
      pos1  = VW'(pos_ff) + VW'(1);
      m     = (new_r_mag_src > new_l_mag_src) ? new_r_mag_src : new_l_mag_src;
      rp1   = past_ff ? '0 : rp_ff;
      rp2   = (m > rp1) ? m : rp1;
      ws1   = past_ff ? WS_W'(pos_ff) : ws_ff;
      done  = (WSUM_W'(pos_ff) + WSUM_W'(1)) >= wnext_ff;
      if (cmd.emit_write) begin
         if (kind_ff == slls_pkg::KIND_APPEND) begin
            if (VW'(vc_ff) < VW'(LOOP_DEPTH)) begin
               vc_in = vc_ff + CW'(1);
            end
         end else if (VW'(vc_ff) < pos1) begin
            vc_in = pos1[CW-1:0];
         end
         if (spp_ff != '0) begin
            if (done) begin
               pv    = 1'b1;
               pval  = rp2;
               pidx  = pc_ff;
               pc_in = pc_ff + PIW'(1);
               ws_in = wnext_ff[WS_W-1:0];
               rp_in = '0;
            end else begin
               ws_in = ws1;
               rp_in = rp2;
            end
         end
      end
      if (cmd.emit_misc) begin
         if (kind_ff == slls_pkg::KIND_CLEAR) begin
            vc_in = '0;
            ws_in = '0;
            rp_in = '0;
            pc_in = '0;
         end else if (kind_ff == slls_pkg::KIND_RESTART) begin
            ws_in = '0;
            rp_in = '0;
            pc_in = '0;
         end
      end
   end

   logic          emit;
   logic [VW-1:0] cnt_ext;
   assign emit    = cmd.emit_play | cmd.emit_write | cmd.emit_misc;
   assign cnt_ext = VW'(vc_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff          <= '0;
         ws_ff          <= '0;
         rp_ff          <= '0;
         pc_ff          <= '0;
         rsp_peak_valid <= 1'b0;
      end else begin
         vc_ff <= vc_in;
         ws_ff <= ws_in;
         rp_ff <= rp_in;
         pc_ff <= pc_in;
         if (emit) begin
            rsp_peak_valid <= pv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_out_left     <= cmd.emit_play ? mixl : '0;
         rsp_out_right    <= cmd.emit_play ? mixr : '0;
         rsp_peak_value   <= pval;
         rsp_peak_index   <= pidx;
         rsp_stored_count <= cnt_ext[slls_pkg::COUNT_W-1:0];
      end
   end

   a_peak_needs_window: assert property (@(posedge clock) disable iff (reset)
      ($past(emit) && rsp_peak_valid) |-> ($past(spp_ff) != '0))
      else $error("peak reported with peak windows disabled");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.emit_write) |-> (VW'(vc_ff) <= VW'(LOOP_DEPTH)))
      else $error("stored count above loop depth");

   a_single_emit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.emit_play, cmd.emit_write, cmd.emit_misc}))
      else $error("more than one emit step at once");

endmodule

FILE: hw/rtl/stereo_loop_layer_store.sv
// ----------------------------------------------------------------------------
// stereo_loop_layer_store
// One layer of a stereo looper: loop memory with append, overdub, gained
// play mix, clear and a windowed peak meter.
// Per beat the sequencer runs READ, EXEC, PEAK (append/overdub), READ, EXEC,
// SCALE, MIX (play) or READ alone (clear/restart/out-of-range writes), then
// rsp_strobe; one beat at a time, set by the single-port read-modify-write and
// the three-multiply gain chain. rsp_strobe is a one-cycle pulse; no back-pressure.
// Reset and every clear run a sweep zeroing the whole memory, with busy high;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module stereo_loop_layer_store #(
   parameter int LOOP_DEPTH  = slls_pkg::LOOP_DEPTH,
   parameter int SAMPLE_BITS = slls_pkg::SAMPLE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [slls_pkg::KIND_W-1:0]       req_kind,
   input  logic [slls_pkg::POS_W-1:0]        req_position,
   input  logic signed [SAMPLE_BITS-1:0]     req_in_left,
   input  logic signed [SAMPLE_BITS-1:0]     req_in_right,
   input  logic signed [SAMPLE_BITS-1:0]     req_bus_left,
   input  logic signed [SAMPLE_BITS-1:0]     req_bus_right,
   output logic                              rsp_strobe,
   output logic signed [SAMPLE_BITS-1:0]     rsp_out_left,
   output logic signed [SAMPLE_BITS-1:0]     rsp_out_right,
   output logic                              rsp_peak_valid,
   output logic [SAMPLE_BITS-1:0]            rsp_peak_value,
   output logic [slls_pkg::PEAK_IDX_W-1:0]   rsp_peak_index,
   output logic [slls_pkg::COUNT_W-1:0]      rsp_stored_count,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [slls_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [slls_pkg::CSR_DATA_W-1:0]   csr_data
);

   slls_pkg::ctrl_cmd_type  cmd;
   slls_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   slls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   slls_datapath #(
      .LOOP_DEPTH  (LOOP_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_kind         (req_kind),
      .req_position     (req_position),
      .req_in_left      (req_in_left),
      .req_in_right     (req_in_right),
      .req_bus_left     (req_bus_left),
      .req_bus_right    (req_bus_right),
      .cmd              (cmd),
      .status           (status),
      .rsp_out_left     (rsp_out_left),
      .rsp_out_right    (rsp_out_right),
      .rsp_peak_valid   (rsp_peak_valid),
      .rsp_peak_value   (rsp_peak_value),
      .rsp_peak_index   (rsp_peak_index),
      .rsp_stored_count (rsp_stored_count)
   );

endmodule
